[rtl/core/rqn_pkg.sv]
// Shared types, constants and the product sequence table for the ray/quad picker.
package rqn_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ID_BITS_DEF   = 32;
    localparam int CRD_W  = 32;
    localparam int VEC_W  = 33;
    localparam int WVEC_W = 67;
    localparam int ACC_W  = 128;
    localparam int QUO_W  = 32;
    localparam int DIST_W = 31;
    localparam int EPS_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TERM_CNT  = 24;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 3'd6;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } vert_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  q;
        logic              ovf;
        logic              neg;
    } div_res_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [DIST_W-1:0] hit_dist;
    } lane_res_t;

    typedef enum logic [1:0] {AV_DIR, AV_E1, AV_E2, AV_T} avec_t;
    typedef enum logic [1:0] {BV_E1, BV_E2, BV_P, BV_Q} bvec_t;
    typedef enum logic [3:0] {
        DS_P0, DS_P1, DS_P2, DS_DET, DS_TP, DS_Q0, DS_Q1, DS_Q2, DS_DQ, DS_EQ
    } dst_t;

    typedef struct packed {
        avec_t       av;
        logic [1:0]  ac;
        bvec_t       bv;
        logic [1:0]  bc;
        logic        sub;
        logic        fin;
        dst_t        dst;
    } term_t;

    function automatic term_t mk(avec_t av, logic [1:0] ac, bvec_t bv, logic [1:0] bc,
                                 logic sub, logic fin, dst_t dst);
        term_t t;
        t.av = av; t.ac = ac; t.bv = bv; t.bc = bc;
        t.sub = sub; t.fin = fin; t.dst = dst;
        return t;
    endfunction

    // p = dir x e2, det = e1.p, tp = t.p, q = t x e1, dq = dir.q, eq = e2.q
    function automatic term_t term_rom(logic [4:0] k);
        term_t t;
        case (k)
            5'd0:  t = mk(AV_DIR, 2'd1, BV_E2, 2'd2, 1'b0, 1'b0, DS_P0);
            5'd1:  t = mk(AV_DIR, 2'd2, BV_E2, 2'd1, 1'b1, 1'b1, DS_P0);
            5'd2:  t = mk(AV_DIR, 2'd2, BV_E2, 2'd0, 1'b0, 1'b0, DS_P1);
            5'd3:  t = mk(AV_DIR, 2'd0, BV_E2, 2'd2, 1'b1, 1'b1, DS_P1);
            5'd4:  t = mk(AV_DIR, 2'd0, BV_E2, 2'd1, 1'b0, 1'b0, DS_P2);
            5'd5:  t = mk(AV_DIR, 2'd1, BV_E2, 2'd0, 1'b1, 1'b1, DS_P2);
            5'd6:  t = mk(AV_E1,  2'd0, BV_P,  2'd0, 1'b0, 1'b0, DS_DET);
            5'd7:  t = mk(AV_E1,  2'd1, BV_P,  2'd1, 1'b0, 1'b0, DS_DET);
            5'd8:  t = mk(AV_E1,  2'd2, BV_P,  2'd2, 1'b0, 1'b1, DS_DET);
            5'd9:  t = mk(AV_T,   2'd0, BV_P,  2'd0, 1'b0, 1'b0, DS_TP);
            5'd10: t = mk(AV_T,   2'd1, BV_P,  2'd1, 1'b0, 1'b0, DS_TP);
            5'd11: t = mk(AV_T,   2'd2, BV_P,  2'd2, 1'b0, 1'b1, DS_TP);
            5'd12: t = mk(AV_T,   2'd1, BV_E1, 2'd2, 1'b0, 1'b0, DS_Q0);
            5'd13: t = mk(AV_T,   2'd2, BV_E1, 2'd1, 1'b1, 1'b1, DS_Q0);
            5'd14: t = mk(AV_T,   2'd2, BV_E1, 2'd0, 1'b0, 1'b0, DS_Q1);
            5'd15: t = mk(AV_T,   2'd0, BV_E1, 2'd2, 1'b1, 1'b1, DS_Q1);
            5'd16: t = mk(AV_T,   2'd0, BV_E1, 2'd1, 1'b0, 1'b0, DS_Q2);
            5'd17: t = mk(AV_T,   2'd1, BV_E1, 2'd0, 1'b1, 1'b1, DS_Q2);
            5'd18: t = mk(AV_DIR, 2'd0, BV_Q,  2'd0, 1'b0, 1'b0, DS_DQ);
            5'd19: t = mk(AV_DIR, 2'd1, BV_Q,  2'd1, 1'b0, 1'b0, DS_DQ);
            5'd20: t = mk(AV_DIR, 2'd2, BV_Q,  2'd2, 1'b0, 1'b1, DS_DQ);
            5'd21: t = mk(AV_E2,  2'd0, BV_Q,  2'd0, 1'b0, 1'b0, DS_EQ);
            5'd22: t = mk(AV_E2,  2'd1, BV_Q,  2'd1, 1'b0, 1'b0, DS_EQ);
            5'd23: t = mk(AV_E2,  2'd2, BV_Q,  2'd2, 1'b0, 1'b1, DS_EQ);
            default: t = mk(AV_DIR, 2'd0, BV_E1, 2'd0, 1'b0, 1'b0, DS_P0);
        endcase
        return t;
    endfunction

endpackage

[rtl/core/rqn_div.sv]
// Restoring divider: 32-bit quotient magnitude plus overflow and sign.
module rqn_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [rqn_pkg::ACC_W-1:0] num,
    input  logic signed [rqn_pkg::ACC_W-1:0] den,
    output rqn_pkg::div_res_t                res
);
    localparam int AW = rqn_pkg::ACC_W;
    localparam int QW = rqn_pkg::QUO_W;
    localparam int SW = AW + QW;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_CHK  = 3'b010,
        D_RUN  = 3'b100
    } dstate_t;

    dstate_t         st_reg, st_next;
    logic [AW-1:0]   rem_reg, rem_next;
    logic [SW-1:0]   ds_reg, ds_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic            neg_reg, neg_next;
    logic            done_reg, done_next;
    logic [SW-1:0]   rem_ext;
    logic            ge;

    assign rem_ext = {{QW{1'b0}}, rem_reg};
    assign ge      = rem_ext >= ds_reg;

    always_comb begin
        st_next   = st_reg;
        rem_next  = rem_reg;
        ds_next   = ds_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        case (st_reg)
            D_IDLE: begin
                if (start) begin
                    rem_next = num[AW-1] ? AW'(-num) : AW'(num);
                    ds_next  = {{QW{1'b0}}, (den[AW-1] ? AW'(-den) : AW'(den))};
                    neg_next = num[AW-1] ^ den[AW-1];
                    q_next   = '0;
                    st_next  = D_CHK;
                end
            end
            D_CHK: begin
                ovf_next = rem_ext >= (ds_reg << QW);
                ds_next  = ds_reg << (QW - 1);
                cnt_next = 6'(QW);
                if (rem_ext >= (ds_reg << QW)) begin
                    done_next = 1'b1;
                    st_next   = D_IDLE;
                end else begin
                    st_next = D_RUN;
                end
            end
            D_RUN: begin
                if (ge) begin
                    rem_next = rem_reg - ds_reg[AW-1:0];
                end
                q_next   = {q_reg[QW-2:0], ge};
                ds_next  = ds_reg >> 1;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    done_next = 1'b1;
                    st_next   = D_IDLE;
                end
            end
            default: st_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= D_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        ds_reg  <= ds_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    assign res.done = done_reg;
    assign res.q    = q_reg;
    assign res.ovf  = ovf_reg;
    assign res.neg  = neg_reg;
endmodule

[rtl/core/rqn_lane.sv]
// One triangle lane: multiply-accumulate sequencer, hit checks and a divider.
module rqn_lane #(
    parameter int FRAC_BITS = rqn_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  rqn_pkg::vert_t                    va,
    input  rqn_pkg::vert_t                    vb,
    input  rqn_pkg::vert_t                    vc,
    input  rqn_pkg::vert_t                    org,
    input  rqn_pkg::vert_t                    dir,
    input  logic [rqn_pkg::EPS_W-1:0]         eps,
    output rqn_pkg::lane_res_t                res
);
    localparam int VW = rqn_pkg::VEC_W;
    localparam int WW = rqn_pkg::WVEC_W;
    localparam int AW = rqn_pkg::ACC_W;
    localparam int QW = rqn_pkg::QUO_W;
    localparam int HW = WW - VW;
    localparam logic [QW:0] ONE = (QW+1)'(1) << FRAC_BITS;

    typedef enum logic [6:0] {
        L_IDLE = 7'b0000001,
        L_MAC  = 7'b0000010,
        L_CHK  = 7'b0000100,
        L_U    = 7'b0001000,
        L_V    = 7'b0010000,
        L_T    = 7'b0100000,
        L_DONE = 7'b1000000
    } lstate_t;

    lstate_t                st_reg, st_next;
    logic signed [VW-1:0]   dir_reg [3];
    logic signed [VW-1:0]   e1_reg [3];
    logic signed [VW-1:0]   e2_reg [3];
    logic signed [VW-1:0]   t_reg [3];
    logic signed [WW-1:0]   p_reg [3];
    logic signed [WW-1:0]   q_reg [3];
    logic signed [AW-1:0]   det_reg, tp_reg, dq_reg, eq_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [4:0]             k_reg;
    logic                   ph_reg;
    logic [QW-1:0]          u_reg;
    logic                   hit_reg;
    logic [rqn_pkg::DIST_W-1:0] dist_reg;

    rqn_pkg::term_t         tm;
    logic signed [VW-1:0]   a_op;
    logic signed [WW-1:0]   b_op;
    logic signed [HW:0]     b_part;
    logic signed [WW-1:0]   prod;
    logic signed [AW-1:0]   prod_sh;
    logic signed [AW-1:0]   acc_sum;
    logic                   div_start;
    logic signed [AW-1:0]   div_num;
    rqn_pkg::div_res_t      dres;
    logic                   q_neg, q_zero;
    logic [AW-1:0]          det_abs;
    logic [QW:0]            uv_sum;

    assign tm = rqn_pkg::term_rom(k_reg);

    always_comb begin
        case (tm.av)
            rqn_pkg::AV_DIR: a_op = dir_reg[tm.ac];
            rqn_pkg::AV_E1:  a_op = e1_reg[tm.ac];
            rqn_pkg::AV_E2:  a_op = e2_reg[tm.ac];
            rqn_pkg::AV_T:   a_op = t_reg[tm.ac];
            default:         a_op = dir_reg[tm.ac];
        endcase
        case (tm.bv)
            rqn_pkg::BV_E1:  b_op = WW'(e1_reg[tm.bc]);
            rqn_pkg::BV_E2:  b_op = WW'(e2_reg[tm.bc]);
            rqn_pkg::BV_P:   b_op = p_reg[tm.bc];
            rqn_pkg::BV_Q:   b_op = q_reg[tm.bc];
            default:         b_op = p_reg[tm.bc];
        endcase
    end

    assign b_part  = ph_reg ? $signed(b_op[WW-1:VW]) : $signed({1'b0, b_op[VW-1:0]});
    assign prod    = a_op * b_part;
    assign prod_sh = ph_reg ? (AW'(prod) <<< VW) : AW'(prod);
    assign acc_sum = tm.sub ? acc_reg - prod_sh : acc_reg + prod_sh;

    assign q_zero  = (dres.q == '0) && !dres.ovf;
    assign q_neg   = dres.neg && !q_zero;
    assign det_abs = det_reg[AW-1] ? AW'(-det_reg) : AW'(det_reg);
    assign uv_sum  = {1'b0, u_reg} + {1'b0, dres.q};

    always_comb begin
        case (st_reg)
            L_CHK:   div_num = tp_reg <<< FRAC_BITS;
            L_U:     div_num = dq_reg <<< FRAC_BITS;
            default: div_num = eq_reg <<< FRAC_BITS;
        endcase
    end

    always_comb begin
        st_next   = st_reg;
        div_start = 1'b0;
        case (st_reg)
            L_IDLE, L_DONE: begin
                if (start) st_next = L_MAC;
            end
            L_MAC: begin
                if (ph_reg && tm.fin && k_reg == 5'(rqn_pkg::TERM_CNT - 1)) st_next = L_CHK;
            end
            L_CHK: begin
                if (det_reg == '0 || det_abs < (AW'(eps) << (2 * FRAC_BITS))) begin
                    st_next = L_DONE;
                end else begin
                    div_start = 1'b1;
                    st_next   = L_U;
                end
            end
            L_U: begin
                if (dres.done) begin
                    if (q_neg || dres.ovf || {1'b0, dres.q} > ONE) begin
                        st_next = L_DONE;
                    end else begin
                        div_start = 1'b1;
                        st_next   = L_V;
                    end
                end
            end
            L_V: begin
                if (dres.done) begin
                    if (q_neg || dres.ovf || uv_sum > ONE) begin
                        st_next = L_DONE;
                    end else begin
                        div_start = 1'b1;
                        st_next   = L_T;
                    end
                end
            end
            L_T: begin
                if (dres.done) st_next = L_DONE;
            end
            default: st_next = L_IDLE;
        endcase
    end

    rqn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (det_reg),
        .res     (dres)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= L_IDLE;
            hit_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == L_MAC && st_next == L_CHK) hit_reg <= 1'b0;
            if (st_reg == L_T && dres.done) begin
                hit_reg <= !q_neg && (dres.ovf || dres.q > QW'(eps));
            end
        end
        if (st_reg == L_T && dres.done) begin
            dist_reg <= (dres.ovf || dres.q[QW-1]) ? rqn_pkg::DIST_MAX
                                                  : dres.q[rqn_pkg::DIST_W-1:0];
        end
        if (st_reg == L_U && dres.done) u_reg <= dres.q;
        if ((st_reg == L_IDLE || st_reg == L_DONE) && start) begin
            dir_reg[0] <= VW'(dir.x);
            dir_reg[1] <= VW'(dir.y);
            dir_reg[2] <= VW'(dir.z);
            e1_reg[0]  <= VW'(vb.x) - VW'(va.x);
            e1_reg[1]  <= VW'(vb.y) - VW'(va.y);
            e1_reg[2]  <= VW'(vb.z) - VW'(va.z);
            e2_reg[0]  <= VW'(vc.x) - VW'(va.x);
            e2_reg[1]  <= VW'(vc.y) - VW'(va.y);
            e2_reg[2]  <= VW'(vc.z) - VW'(va.z);
            t_reg[0]   <= VW'(org.x) - VW'(va.x);
            t_reg[1]   <= VW'(org.y) - VW'(va.y);
            t_reg[2]   <= VW'(org.z) - VW'(va.z);
            acc_reg    <= '0;
            k_reg      <= '0;
            ph_reg     <= 1'b0;
        end else if (st_reg == L_MAC) begin
            ph_reg <= !ph_reg;
            if (ph_reg) begin
                k_reg <= k_reg + 5'd1;
                if (tm.fin) begin
                    acc_reg <= '0;
                    case (tm.dst)
                        rqn_pkg::DS_P0:  p_reg[0] <= WW'(acc_sum);
                        rqn_pkg::DS_P1:  p_reg[1] <= WW'(acc_sum);
                        rqn_pkg::DS_P2:  p_reg[2] <= WW'(acc_sum);
                        rqn_pkg::DS_DET: det_reg  <= acc_sum;
                        rqn_pkg::DS_TP:  tp_reg   <= acc_sum;
                        rqn_pkg::DS_Q0:  q_reg[0] <= WW'(acc_sum);
                        rqn_pkg::DS_Q1:  q_reg[1] <= WW'(acc_sum);
                        rqn_pkg::DS_Q2:  q_reg[2] <= WW'(acc_sum);
                        rqn_pkg::DS_DQ:  dq_reg   <= acc_sum;
                        rqn_pkg::DS_EQ:  eq_reg   <= acc_sum;
                        default:         det_reg  <= acc_sum;
                    endcase
                end else begin
                    acc_reg <= acc_sum;
                end
            end else begin
                acc_reg <= acc_sum;
            end
        end
    end

    assign res.done     = (st_reg == L_DONE);
    assign res.hit      = hit_reg;
    assign res.hit_dist = dist_reg;
endmodule

[rtl/core/ray_quad_nearest_hit.sv]
// Top level: config registers, two triangle lanes, nearest-hit merge and result register.
//
//  channel  dir  handshake              payload
//  s_       in   s_valid / s_ready      window id, four corners, last
//  m_       out  m_valid / m_ready      picked window, hit flag, distance
//  cfg_     in   cfg_valid / cfg_ready  register index, data
//
// Each lane works through its multiply-accumulate terms on one 33x34 multiplier
// per lane and then runs up to three divisions.
// Both triangles of a quad run side by side; the next quad is taken after the merge.
// Reset clears the pick and sets origin and direction to zero, epsilon to one.
// A full result register holds the merge of a last quad; other quads proceed.
module ray_quad_nearest_hit #(
    parameter int FRAC_BITS = rqn_pkg::FRAC_BITS_DEF,
    parameter int ID_BITS   = rqn_pkg::ID_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rqn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [31:0]                         s_window_id,
    input  logic [63:0]                         s_top_left_xy,
    input  logic [63:0]                         s_top_right_xy,
    input  logic [63:0]                         s_bottom_right_xy,
    input  logic [63:0]                         s_bottom_left_xy,
    input  logic signed [31:0]                  s_top_left_z,
    input  logic signed [31:0]                  s_top_right_z,
    input  logic signed [31:0]                  s_bottom_right_z,
    input  logic signed [31:0]                  s_bottom_left_z,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [31:0]                         m_picked_window,
    output logic                                m_hit_found,
    output logic [rqn_pkg::DIST_W-1:0]          m_nearest_distance
);
    localparam int KW = (ID_BITS < 32) ? ID_BITS : 32;
    localparam int DW = rqn_pkg::DIST_W;

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_RUN  = 2'b10
    } tstate_t;

    tstate_t               st_reg, st_next;
    rqn_pkg::vert_t        org_reg, dir_reg;
    logic [rqn_pkg::EPS_W-1:0] eps_reg;
    logic [KW-1:0]         id_reg;
    logic                  last_reg;
    logic [DW-1:0]         best_dist_reg, best_dist_next;
    logic [KW-1:0]         best_win_reg, best_win_next;
    logic                  hit_any_reg, hit_any_next;
    logic                  m_valid_reg;
    logic [31:0]           m_win_reg;
    logic                  m_hit_reg;
    logic [DW-1:0]         m_dist_reg;

    rqn_pkg::vert_t        v_tl, v_tr, v_br, v_bl;
    rqn_pkg::lane_res_t    r0, r1;
    logic                  accept, merge, qhit;
    logic [DW-1:0]         qdist;

    assign v_tl = '{x: s_top_left_xy[31:0],     y: s_top_left_xy[63:32],     z: s_top_left_z};
    assign v_tr = '{x: s_top_right_xy[31:0],    y: s_top_right_xy[63:32],    z: s_top_right_z};
    assign v_br = '{x: s_bottom_right_xy[31:0], y: s_bottom_right_xy[63:32], z: s_bottom_right_z};
    assign v_bl = '{x: s_bottom_left_xy[31:0],  y: s_bottom_left_xy[63:32],  z: s_bottom_left_z};

    assign cfg_ready = 1'b1;
    assign s_ready   = (st_reg == T_IDLE);
    assign accept    = s_valid && s_ready;

    rqn_lane #(.FRAC_BITS(FRAC_BITS)) u_lane0 (
        .aclk (aclk), .aresetn (aresetn), .start (accept),
        .va (v_tl), .vb (v_tr), .vc (v_br),
        .org (org_reg), .dir (dir_reg), .eps (eps_reg), .res (r0)
    );

    rqn_lane #(.FRAC_BITS(FRAC_BITS)) u_lane1 (
        .aclk (aclk), .aresetn (aresetn), .start (accept),
        .va (v_tl), .vb (v_br), .vc (v_bl),
        .org (org_reg), .dir (dir_reg), .eps (eps_reg), .res (r1)
    );

    assign merge = (st_reg == T_RUN) && r0.done && r1.done
                   && (!last_reg || !m_valid_reg || m_ready);
    assign qhit  = r0.hit || r1.hit;
    assign qdist = r0.hit ? r0.hit_dist : r1.hit_dist;

    always_comb begin
        st_next        = st_reg;
        best_dist_next = best_dist_reg;
        best_win_next  = best_win_reg;
        hit_any_next   = hit_any_reg;
        case (st_reg)
            T_IDLE: begin
                if (accept) st_next = T_RUN;
            end
            T_RUN: begin
                if (merge) begin
                    st_next = T_IDLE;
                    if (qhit && (!hit_any_reg || qdist < best_dist_reg)) begin
                        best_dist_next = qdist;
                        best_win_next  = id_reg;
                    end
                    hit_any_next = hit_any_reg || qhit;
                end
            end
            default: st_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= T_IDLE;
            org_reg       <= '0;
            dir_reg       <= '0;
            eps_reg       <= rqn_pkg::EPS_W'(1);
            best_dist_reg <= rqn_pkg::DIST_MAX;
            best_win_reg  <= '0;
            hit_any_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_valid) begin
                case (cfg_index)
                    rqn_pkg::CFG_ORIGIN_X: org_reg.x <= cfg_data;
                    rqn_pkg::CFG_ORIGIN_Y: org_reg.y <= cfg_data;
                    rqn_pkg::CFG_ORIGIN_Z: org_reg.z <= cfg_data;
                    rqn_pkg::CFG_DIR_X:    dir_reg.x <= cfg_data;
                    rqn_pkg::CFG_DIR_Y:    dir_reg.y <= cfg_data;
                    rqn_pkg::CFG_DIR_Z:    dir_reg.z <= cfg_data;
                    rqn_pkg::CFG_EPSILON:  eps_reg   <= cfg_data[rqn_pkg::EPS_W-1:0];
                    default: ;
                endcase
            end
            if (merge && last_reg) begin
                m_valid_reg   <= 1'b1;
                best_dist_reg <= rqn_pkg::DIST_MAX;
                best_win_reg  <= '0;
                hit_any_reg   <= 1'b0;
            end else begin
                if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
                best_dist_reg <= best_dist_next;
                best_win_reg  <= best_win_next;
                hit_any_reg   <= hit_any_next;
            end
        end
        if (accept) begin
            id_reg   <= s_window_id[KW-1:0];
            last_reg <= s_last;
        end
        if (merge && last_reg) begin
            m_win_reg  <= 32'(best_win_next);
            m_hit_reg  <= hit_any_next;
            m_dist_reg <= best_dist_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_picked_window    = m_win_reg;
    assign m_hit_found        = m_hit_reg;
    assign m_nearest_distance = m_dist_reg;
endmodule
